>>> rtl/bit_pkg.sv
// Package for the baseline intrusion tracker: modes, events, states, widths, config indices, reset values.
// No dependencies.
`default_nettype none
package bit_pkg;
    localparam int MAX_CAL_FRAMES_DEF = 255;
    localparam int DIST_BITS_DEF      = 13;
    localparam int TIME_BITS_DEF      = 40;
    localparam int CFG_BITS           = 32;
    localparam int RATIO_BITS         = 11;
    localparam int SPEED_BITS         = 16;

    localparam logic [1:0] CFG_CAL_START = 2'd0;
    localparam logic [1:0] CFG_CAL_END   = 2'd1;
    localparam logic [1:0] CFG_RATIO     = 2'd2;

    localparam logic [31:0] CAL_START_RST = 32'd2000000;
    localparam logic [31:0] CAL_END_RST   = 32'd5000000;
    localparam logic [10:0] RATIO_RST     = 11'd973;
    localparam logic [16:0] US_SCALE      = 17'd62500;

    typedef enum logic [1:0] {
        MODE_CAL   = 2'd0,
        MODE_ARMED = 2'd1,
        MODE_TRACK = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_DETECT = 2'd1,
        EV_EXIT   = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_THR, ST_SQRT, ST_SPEED, ST_OUT
    } state_t;

    // per-lane compare flags toward the sequencer
    typedef struct packed {
        logic below;   // reading nonzero and under threshold
        logic above;   // reading over threshold
    } lane_flag_t;
endpackage
`default_nettype wire

>>> rtl/bit_lane.sv
// One axis lane: calibration sum, baseline divide, threshold, compares, squared delta.
// Depends on bit_pkg.
`default_nettype none
module bit_lane import bit_pkg::*; #(
    parameter int DIST_BITS      = DIST_BITS_DEF,
    parameter int MAX_CAL_FRAMES = MAX_CAL_FRAMES_DEF,
    localparam int CNT_BITS      = $clog2(MAX_CAL_FRAMES + 1),
    localparam int SUM_BITS      = DIST_BITS + CNT_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [DIST_BITS-1:0]  reading,
    input  wire logic                  acc_en,     // add reading to sum
    input  wire logic                  div_start,  // load divider
    input  wire logic                  div_step,   // one quotient bit
    input  wire logic                  thr_load,   // scale baseline into threshold
    input  wire logic                  entry_load, // latch entry reading
    input  wire logic [CNT_BITS-1:0]   count,
    input  wire logic [RATIO_BITS-1:0] ratio,
    output lane_flag_t                 flag,
    output logic [2*DIST_BITS-1:0]     delta_sq_reg
);
    logic [SUM_BITS-1:0]  sum_reg;
    logic [SUM_BITS-1:0]  quo_reg;   // shifts sum in, quotient out
    logic [CNT_BITS:0]    rem_reg;
    logic [DIST_BITS-1:0] thr_reg;
    logic [DIST_BITS-1:0] entry_reg;
    logic [CNT_BITS:0]    rem_try;
    logic [SUM_BITS+RATIO_BITS-1:0] prod;
    logic [SUM_BITS+RATIO_BITS-11:0] scaled;
    logic [DIST_BITS-1:0] adiff;

    assign rem_try = {rem_reg[CNT_BITS-1:0], quo_reg[SUM_BITS-1]};
    assign prod    = {{RATIO_BITS{1'b0}}, quo_reg} * {{SUM_BITS{1'b0}}, ratio};
    assign scaled  = prod[SUM_BITS+RATIO_BITS-1:10];
    assign adiff   = (reading > entry_reg) ? reading - entry_reg : entry_reg - reading;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            thr_reg <= '0;
        end else begin
            if (acc_en)
                sum_reg <= sum_reg + SUM_BITS'(reading);
            if (thr_load)
                thr_reg <= (count == '0) ? '0 :
                    (scaled > {DIST_BITS{1'b1}}) ? {DIST_BITS{1'b1}} : DIST_BITS'(scaled);
        end
    end

    // restoring divide, one bit a cycle while div_step is high
    always_ff @(posedge aclk) begin
        if (div_start) begin
            quo_reg <= sum_reg;
            rem_reg <= '0;
        end else if (div_step) begin
            if (rem_try >= {1'b0, count}) begin
                rem_reg <= rem_try - {1'b0, count};
                quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= rem_try;
                quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b0};
            end
        end
        if (entry_load)
            entry_reg <= reading;
        delta_sq_reg <= {{DIST_BITS{1'b0}}, adiff} * {{DIST_BITS{1'b0}}, adiff};
    end

    assign flag.below = (reading != '0) && (reading < thr_reg);
    assign flag.above = reading > thr_reg;
endmodule
`default_nettype wire

>>> rtl/bit_merge.sv
// Merge stage: sum of squares, iterative square root and speed divide.
// Depends on bit_pkg.
`default_nettype none
module bit_merge import bit_pkg::*; #(
    parameter int DIST_BITS = DIST_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    localparam int SQ_BITS   = 2 * DIST_BITS + 2,
    localparam int ROOT_BITS = DIST_BITS + 1,
    localparam int NUM_BITS  = ROOT_BITS + 17
) (
    input  wire logic                   aclk,
    input  wire logic [2*DIST_BITS-1:0] sq_x,
    input  wire logic [2*DIST_BITS-1:0] sq_y,
    input  wire logic [2*DIST_BITS-1:0] sq_z,
    input  wire logic [TIME_BITS-1:0]   dt,
    input  wire logic                   sqrt_start,
    input  wire logic                   sqrt_step,
    input  wire logic                   spd_start,
    input  wire logic                   spd_step,
    output logic [SPEED_BITS-1:0]       speed
);
    localparam int DEN_BITS = TIME_BITS + NUM_BITS + 1;
    logic [SQ_BITS-1:0]   rad_reg;
    logic [SQ_BITS-1:0]   rem_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [SQ_BITS-1:0]   trial;
    logic [SQ_BITS-1:0]   rem_sh;
    logic [NUM_BITS-1:0]  num_reg;
    logic [NUM_BITS-1:0]  q_reg;
    logic [DEN_BITS-1:0]  drem_reg;
    logic [DEN_BITS-1:0]  drem_sh;
    logic [TIME_BITS-1:0] dt_reg;

    assign rem_sh  = {rem_reg[SQ_BITS-3:0], rad_reg[SQ_BITS-1:SQ_BITS-2]};
    assign trial   = SQ_BITS'({root_reg[ROOT_BITS-1:0], 2'b01});
    assign drem_sh = {drem_reg[DEN_BITS-2:0], num_reg[NUM_BITS-1]};

    always_ff @(posedge aclk) begin
        // digit-by-digit square root, two radicand bits a step
        if (sqrt_start) begin
            rad_reg  <= SQ_BITS'(sq_x) + SQ_BITS'(sq_y) + SQ_BITS'(sq_z);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (sqrt_step) begin
            rad_reg <= {rad_reg[SQ_BITS-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_BITS-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_BITS-2:0], 1'b0};
            end
        end
        // restoring divide of root*62500 by dt
        if (spd_start) begin
            num_reg  <= NUM_BITS'(root_reg) * NUM_BITS'(US_SCALE);
            q_reg    <= '0;
            drem_reg <= '0;
            dt_reg   <= dt;
        end else if (spd_step) begin
            num_reg <= {num_reg[NUM_BITS-2:0], 1'b0};
            if (drem_sh >= DEN_BITS'(dt_reg)) begin
                drem_reg <= drem_sh - DEN_BITS'(dt_reg);
                q_reg    <= {q_reg[NUM_BITS-2:0], 1'b1};
            end else begin
                drem_reg <= drem_sh;
                q_reg    <= {q_reg[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    // zero dt saturates speed to all ones, or gives zero when the root is zero
    always_comb begin
        if (dt_reg == '0)
            speed = (root_reg != '0) ? '1 : '0;
        else if (q_reg > NUM_BITS'({SPEED_BITS{1'b1}}))
            speed = '1;
        else
            speed = q_reg[SPEED_BITS-1:0];
    end
endmodule
`default_nettype wire

>>> rtl/baseline_intrusion_tracker.sv
// Baseline intrusion tracker: three axis lanes plus a merge stage under one sequencer.
// A plain frame is decided in ST_OUT and loads the result register; an arming frame adds the
// ST_DIV baseline divide and ST_THR; an exit frame adds ST_SQRT and the ST_DIV speed divide.
// One frame in flight: the next beat can be taken in the cycle after the result beat leaves.
// Reset (aresetn, synchronous): calibrating, sums/thresholds zero, registers at defaults.
// Depends on bit_pkg, bit_lane, bit_merge.
`default_nettype none
module baseline_intrusion_tracker import bit_pkg::*; #(
    parameter int MAX_CAL_FRAMES = MAX_CAL_FRAMES_DEF,
    parameter int DIST_BITS      = DIST_BITS_DEF,
    parameter int TIME_BITS      = TIME_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // time_us, dist_x, dist_y, dist_z from bit 0 up, zero padded
    input  wire logic [((TIME_BITS+3*DIST_BITS+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // phase, event_res, speed_cm_per_s, exit_x, exit_y from bit 0 up, zero padded
    output logic [((20+2*DIST_BITS+7)/8)*8-1:0] m_tdata,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [CFG_BITS-1:0] cfg_data
);
    localparam int CNT_BITS  = $clog2(MAX_CAL_FRAMES + 1);
    localparam int SUM_BITS  = DIST_BITS + CNT_BITS;
    localparam int ROOT_BITS = DIST_BITS + 1;
    localparam int NUM_BITS  = ROOT_BITS + 17;
    localparam int STEP_BITS = $clog2(NUM_BITS + SUM_BITS + 1);
    localparam int IN_W      = ((TIME_BITS+3*DIST_BITS+7)/8)*8;
    localparam int OUT_W     = ((20+2*DIST_BITS+7)/8)*8;

    logic [CFG_BITS-1:0]   cal_start_reg, cal_end_reg;
    logic [RATIO_BITS-1:0] ratio_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_start_reg <= CAL_START_RST;
            cal_end_reg   <= CAL_END_RST;
            ratio_reg     <= RATIO_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CAL_START: cal_start_reg <= cfg_data;
                CFG_CAL_END:   cal_end_reg   <= cfg_data;
                CFG_RATIO:     ratio_reg     <= cfg_data[RATIO_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input frame capture
    logic [TIME_BITS-1:0] time_reg, entry_time_reg;
    logic [DIST_BITS-1:0] dist_reg [3];
    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    event_t ev_reg, ev_next;
    logic [CNT_BITS-1:0]  count_reg;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic acc_en, div_start, div_step, thr_load, entry_load;
    logic sqrt_start, sqrt_step, spd_start, spd_step;
    logic out_load;
    lane_flag_t flag [3];
    logic [2*DIST_BITS-1:0] sq [3];
    logic [SPEED_BITS-1:0] speed;
    logic [TIME_BITS-1:0] dt;

    wire s_fire = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            time_reg    <= s_tdata[TIME_BITS-1:0];
            dist_reg[0] <= s_tdata[TIME_BITS +: DIST_BITS];
            dist_reg[1] <= s_tdata[TIME_BITS+DIST_BITS +: DIST_BITS];
            dist_reg[2] <= s_tdata[TIME_BITS+2*DIST_BITS +: DIST_BITS];
        end
        if (entry_load)
            entry_time_reg <= time_reg;
    end

    assign dt = time_reg - entry_time_reg;

    genvar g;
    for (g = 0; g < 3; g++) begin : g_lane
        bit_lane #(.DIST_BITS(DIST_BITS), .MAX_CAL_FRAMES(MAX_CAL_FRAMES)) u_lane (
            .aclk, .aresetn,
            .reading(dist_reg[g]), .acc_en, .div_start, .div_step, .thr_load, .entry_load,
            .count(count_reg), .ratio(ratio_reg), .flag(flag[g]), .delta_sq_reg(sq[g])
        );
    end

    bit_merge #(.DIST_BITS(DIST_BITS), .TIME_BITS(TIME_BITS)) u_merge (
        .aclk, .sq_x(sq[0]), .sq_y(sq[1]), .sq_z(sq[2]), .dt,
        .sqrt_start, .sqrt_step, .spd_start, .spd_step, .speed
    );

    // time compares against the 32-bit window registers
    wire after_start = time_reg > TIME_BITS'(cal_start_reg);
    wire before_end  = time_reg < TIME_BITS'(cal_end_reg);
    wire all_below   = flag[0].below && flag[1].below && flag[2].below;
    wire all_above   = flag[0].above && flag[1].above && flag[2].above;

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        ev_next    = ev_reg;
        step_next  = step_reg;
        {acc_en, div_start, div_step, thr_load, entry_load} = '0;
        {sqrt_start, sqrt_step, spd_start, spd_step, out_load} = '0;
        unique case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_OUT;  // decide in ST_OUT entry below
            ST_OUT: begin
                // decision cycle with the captured frame
                ev_next = EV_NONE;
                unique case (mode_reg)
                    MODE_CAL: if (after_start) begin
                        if (before_end) begin
                            if (count_reg < CNT_BITS'(MAX_CAL_FRAMES)) acc_en = 1'b1;
                            out_load = 1'b1;
                        end else begin
                            div_start  = 1'b1;
                            step_next  = STEP_BITS'(SUM_BITS);
                            state_next = ST_DIV;
                        end
                    end else out_load = 1'b1;
                    MODE_ARMED: begin
                        if (all_below) begin
                            entry_load = 1'b1;
                            mode_next  = MODE_TRACK;
                            ev_next    = EV_DETECT;
                        end
                        out_load = 1'b1;
                    end
                    default: begin
                        if (all_above) begin
                            state_next = ST_SQRT;
                            step_next  = STEP_BITS'(ROOT_BITS + 1);
                        end else out_load = 1'b1;
                    end
                endcase
                if (out_load) state_next = ST_SPEED;
            end
            ST_DIV: if (step_reg != '0) begin
                div_step  = 1'b1;
                step_next = step_reg - 1'b1;
            end else state_next = ST_THR;
            ST_THR: begin
                thr_load   = 1'b1;
                mode_next  = MODE_ARMED;
                ev_next    = EV_NONE;
                out_load   = 1'b1;
                state_next = ST_SPEED;
            end
            ST_SQRT: begin
                // squared deltas were registered from the frame during ST_OUT;
                // load, ROOT_BITS root steps, then the divider start
                if (step_reg == STEP_BITS'(ROOT_BITS + 1)) sqrt_start = 1'b1;
                else if (step_reg != '0) sqrt_step = 1'b1;
                if (step_reg == '0) begin
                    spd_start  = 1'b1;
                    step_next  = STEP_BITS'(NUM_BITS);
                    state_next = ST_DIV;
                    mode_next  = MODE_ARMED;
                    ev_next    = EV_EXIT;
                end else step_next = step_reg - 1'b1;
            end
            ST_SPEED: if (m_tvalid && !m_tready) state_next = ST_SPEED;
                      else if (!m_tvalid) state_next = ST_IDLE;
                      else state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        // exit path reuses ST_DIV timing for the speed divider
        if (state_reg == ST_DIV && ev_reg == EV_EXIT && mode_reg == MODE_ARMED) begin
            div_step = 1'b0;
            if (step_reg != '0) spd_step = 1'b1;
            else begin
                state_next = ST_SPEED;
                out_load   = 1'b1;
            end
        end
    end

    // result register
    logic                  ovalid_reg;
    logic [1:0]            o_phase_reg, o_ev_reg;
    logic [SPEED_BITS-1:0] o_speed_reg;
    logic [DIST_BITS-1:0]  o_x_reg, o_y_reg;
    wire  ex = (ev_next == EV_EXIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mode_reg   <= MODE_CAL;
            ev_reg     <= EV_NONE;
            step_reg   <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= (state_next == ST_SPEED && out_load) ? ST_SPEED :
                         (state_reg == ST_SPEED && (ovalid_reg && !m_tready)) ? ST_SPEED :
                         state_next;
            mode_reg  <= mode_next;
            ev_reg    <= ev_next;
            step_reg  <= step_next;
            if (acc_en) count_reg <= count_reg + 1'b1;
            if (out_load) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
        end
        if (out_load) begin
            o_phase_reg <= mode_next;
            o_ev_reg    <= ev_next;
            o_speed_reg <= ex ? speed : '0;
            o_x_reg     <= ex ? dist_reg[0] : '0;
            o_y_reg     <= ex ? dist_reg[1] : '0;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = OUT_W'({o_y_reg, o_x_reg, o_speed_reg, o_ev_reg, o_phase_reg});
endmodule
`default_nettype wire

>>> verif/baseline_intrusion_tracker_test.sv
// Self-checking bench for baseline_intrusion_tracker: directed and random frame sequences
// through calibration, arming, detection and exit, checked beat by beat.
// Depends on bit_pkg and the baseline_intrusion_tracker RTL.
`timescale 1ns / 1ps
module baseline_intrusion_tracker_test;
    import bit_pkg::*;

    localparam int DB = DIST_BITS_DEF;
    localparam int TB = TIME_BITS_DEF;
    localparam int SW = ((TB + 3*DB + 7)/8)*8;
    localparam int MW = ((20 + 2*DB + 7)/8)*8;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [DB-1:0] dz;
        logic [DB-1:0] dy;
        logic [DB-1:0] dx;
        logic [TB-1:0] t;
    } frame_t;

    typedef struct packed {
        logic [DB-1:0] ey;
        logic [DB-1:0] ex;
        logic [15:0]   speed;
        event_t        ev;
        mode_t         ph;
    } report_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [MW-1:0] m_tdata;
    logic cfg_we = 0;
    logic [1:0] cfg_index = CFG_CAL_START;
    logic [CFG_BITS-1:0] cfg_data = '0;

    baseline_intrusion_tracker DUT (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // tracker state mirrored in the bench
    logic [31:0]   p_start, p_end;
    logic [10:0]   p_ratio;
    mode_t         p_mode;
    logic [20:0]   p_sum [3];
    logic [7:0]    p_cnt;
    logic [DB-1:0] p_thr [3];
    logic [DB-1:0] p_entry [3];
    logic [TB-1:0] p_etime;

    frame_t  frames_pending[$];
    report_t reports_due[$];
    int      src_idle = 14, snk_idle = 60;
    int      hold_sink = 0;
    int      mismatches = 0, beats_out = 0, detects = 0, exits = 0;
    int      quiet = 0;
    bit      feed_done = 0;

    function automatic logic [31:0] isqrt(input logic [31:0] v);
        logic [31:0] r;
        r = 0;
        for (int b = 15; b >= 0; b--)
            if ((r | (32'd1 << b)) * (r | (32'd1 << b)) <= v) r = r | (32'd1 << b);
        return r;
    endfunction

    function automatic report_t track_frame(input frame_t f);
        report_t       r;
        logic [DB-1:0] d [3];
        logic [63:0]   base, thr, d2, disp, dt, spd;
        bit            all;
        d[0] = f.dx; d[1] = f.dy; d[2] = f.dz;
        r = '0;
        r.ev = EV_NONE;
        case (p_mode)
            MODE_CAL: begin
                if (f.t > p_start) begin
                    if (f.t < p_end) begin
                        if (p_cnt < MAX_CAL_FRAMES_DEF) begin
                            for (int i = 0; i < 3; i++) p_sum[i] += d[i];
                            p_cnt++;
                        end
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            base = p_cnt ? p_sum[i] / p_cnt : 0;
                            thr = (base * p_ratio) >> 10;
                            p_thr[i] = thr > {DB{1'b1}} ? {DB{1'b1}} : thr[DB-1:0];
                        end
                        p_mode = MODE_ARMED;
                    end
                end
            end
            MODE_ARMED: begin
                all = 1;
                for (int i = 0; i < 3; i++)
                    if (!(d[i] > 0 && d[i] < p_thr[i])) all = 0;
                if (all) begin
                    for (int i = 0; i < 3; i++) p_entry[i] = d[i];
                    p_etime = f.t;
                    p_mode = MODE_TRACK;
                    r.ev = EV_DETECT;
                end
            end
            default: begin
                all = 1;
                for (int i = 0; i < 3; i++)
                    if (!(d[i] > p_thr[i])) all = 0;
                if (all) begin
                    d2 = 0;
                    for (int i = 0; i < 3; i++) begin
                        base = d[i] > p_entry[i] ? d[i] - p_entry[i] : p_entry[i] - d[i];
                        d2 += base * base;
                    end
                    disp = isqrt(d2[31:0]);
                    dt = {24'd0, f.t - p_etime};
                    if (dt == 0) spd = disp ? 65535 : 0;
                    else begin
                        spd = disp * 62500 / dt;
                        if (spd > 65535) spd = 65535;
                    end
                    r.speed = spd[15:0];
                    r.ex = f.dx;
                    r.ey = f.dy;
                    p_mode = MODE_ARMED;
                    r.ev = EV_EXIT;
                end
            end
        endcase
        r.ph = p_mode;
        return r;
    endfunction

    // driver: one beat per handshake, next frame offered in the same step
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                reports_due.push_back(track_frame(frame_t'(s_tdata[TB+3*DB-1:0])));
                void'(frames_pending.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (frames_pending.size() > 0 && $urandom_range(99) >= src_idle) begin
                    s_tvalid <= 1;
                    s_tdata  <= SW'(frames_pending[0]);
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // monitor plus receiver backpressure
    always @(posedge aclk) begin
        report_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
            else quiet <= quiet + 1;
            if (m_tvalid && m_tready) begin
                got = report_t'(m_tdata[20+2*DB-1:0]);
                beats_out++;
                if (reports_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %h", got);
                end else begin
                    want = reports_due.pop_front();
                    if (got.ev == EV_DETECT) detects++;
                    if (got.ev == EV_EXIT) exits++;
                    if (got.ph !== want.ph || got.ev !== want.ev || got.speed !== want.speed
                            || got.ex !== want.ex || got.ey !== want.ey) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat %0d: exp ph%0d ev%0d sp%0d x%0d y%0d, got ph%0d ev%0d sp%0d x%0d y%0d",
                                beats_out, want.ph, want.ev, want.speed, want.ex, want.ey,
                                got.ph, got.ev, got.speed, got.ex, got.ey);
                    end
                end
            end
            if (hold_sink > 0) begin
                hold_sink <= hold_sink - 1;
                m_tready <= 0;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_idle);
            end
            if (quiet >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_CAL_START: p_start = val;
            CFG_CAL_END:   p_end = val;
            default:       p_ratio = val[10:0];
        endcase
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    // wait until all queued frames went out and every report came back
    task automatic drain();
        while (frames_pending.size() || reports_due.size() || s_tvalid) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic frame_t mk(input logic [TB-1:0] t, input int x, y, z);
        frame_t f;
        f.t = t; f.dx = DB'(x); f.dy = DB'(y); f.dz = DB'(z);
        return f;
    endfunction

    // one well-formed session: calibration, arming, then intrusions
    task automatic session(input int ncal, input int nrest);
        logic [TB-1:0] t;
        int b [3];
        t = TB'(p_start) + 1;
        for (int i = 0; i < 3; i++) b[i] = $urandom_range(8191, 200);
        for (int k = 0; k < ncal; k++) begin
            frames_pending.push_back(mk(t, b[0] - $urandom_range(20), b[1] - $urandom_range(20),
                                        b[2] - $urandom_range(20)));
            t += $urandom_range(3);
        end
        frames_pending.push_back(mk(TB'(p_end) + $urandom_range(5), b[0], b[1], b[2]));
        for (int k = 0; k < nrest; k++) begin
            if ($urandom_range(9) < 7) begin
                frames_pending.push_back(mk(TB'({$urandom, $urandom}),
                    $urandom_range(b[0]/2, 1), $urandom_range(b[1]/2, 1),
                    $urandom_range(b[2]/2, 1)));
                frames_pending.push_back(mk(TB'({$urandom, $urandom}),
                    $urandom_range(8191, b[0]), $urandom_range(8191, b[1]),
                    $urandom_range(8191, b[2])));
            end else begin
                frames_pending.push_back(mk(TB'({$urandom, $urandom}), $urandom, $urandom,
                    $urandom));
            end
        end
    endtask

    initial begin
        p_start = CAL_START_RST; p_end = CAL_END_RST; p_ratio = RATIO_RST;
        p_mode = MODE_CAL; p_cnt = 0;
        for (int i = 0; i < 3; i++) begin
            p_sum[i] = 0; p_thr[i] = 0; p_entry[i] = 0;
        end
        p_etime = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;

        // directed: defaults, ignored frames, extremes, zero dt, wrapping time
        frames_pending.push_back(mk(0, 0, 0, 0));
        frames_pending.push_back(mk(2000000, 8191, 8191, 8191));
        frames_pending.push_back(mk(2000001, 8191, 8191, 8191));
        frames_pending.push_back(mk(4999999, 4000, 4000, 4000));
        frames_pending.push_back(mk(5000000, 1, 1, 1));
        frames_pending.push_back(mk(5000001, 0, 10, 10));
        frames_pending.push_back(mk(5000002, 10, 10, 5999));
        frames_pending.push_back(mk(5000002, 6100, 6100, 6100));
        frames_pending.push_back(mk('1, 1, 1, 1));
        frames_pending.push_back(mk(3, 8191, 8191, 8191));
        frames_pending.push_back(mk(7, 100, 200, 300));
        frames_pending.push_back(mk(7, 8191, 8191, 8191));
        frames_pending.push_back(mk(9, 100, 100, 100));
        frames_pending.push_back(mk(9, 100, 100, 100));
        frames_pending.push_back(mk(9, 8191, 8191, 8191));
        drain();

        // long receiver hold-off while frames keep coming
        hold_sink = 400;
        session(10, 12);
        drain();
        // no calibration frames at all, start after end, ratio of zero
        write_reg(CFG_RATIO, 0);
        write_reg(CFG_CAL_START, '1);
        write_reg(CFG_CAL_END, 0);
        frames_pending.push_back(mk({8'hff, 32'hffffffff}, 5, 5, 5));
        frames_pending.push_back(mk({TB{1'b1}}, 1, 1, 1));
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            src_idle = phase == 0 ? 14 : (phase == 1 ? 60 : 0);
            snk_idle = phase == 0 ? 60 : (phase == 1 ? 14 : 0);
            // only a reset returns to calibration, so sessions start from armed/tracking
            write_reg(CFG_RATIO, phase == 0 ? 1024 : $urandom_range(1024));
            write_reg(CFG_CAL_START, $urandom);
            write_reg(CFG_CAL_END, $urandom);
            for (int s = 0; s < 4; s++) session(0, 17);
            drain();
        end
        write_reg(CFG_CAL_START, 0);
        write_reg(CFG_CAL_END, '1);
        drain();

        $display("Covered %0d result beats: %0d detections, %0d exit reports, long stalls and",
                 beats_out, detects, exits);
        $display("register changes across calibration, armed and tracking phases.");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/bit_pkg.sv
rtl/bit_lane.sv
rtl/bit_merge.sv
rtl/baseline_intrusion_tracker.sv
verif/baseline_intrusion_tracker_test.sv
